[rtl/core/text_integer_extractor_macros.svh]
// Assertion macros for the text integer extractor RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef TEXT_INTEGER_EXTRACTOR_MACROS_SVH
`define TEXT_INTEGER_EXTRACTOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define TIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/tie_pkg.sv]
// Package for the text integer extractor: word types, scan state, characters.
// No dependencies.
`timescale 1ns / 1ps

package tie_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] number_value;
    logic               has_number;
    logic               overflowed;
    logic               string_done;
  } out_word_t;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_PLUS  = 2'd1,
    SIGN_MINUS = 2'd2
  } sign_t;

  typedef struct packed {
    logic        inside_number;
    logic        after_dot;
    logic        is_negative;
    sign_t       pending_sign;
    logic [31:0] magnitude_acc;
    logic        saturated_flag;
  } scan_state_t;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [35:0] MAG_POS_LIMIT = 36'h07FFFFFFF;
  localparam logic [35:0] MAG_NEG_LIMIT = 36'h080000000;

endpackage

[rtl/core/tie_scan_step.sv]
// One scan step: current state and one text byte give next state and result.
// Depends on tie_pkg.
`timescale 1ns / 1ps

module tie_scan_step (
  input  tie_pkg::scan_state_t st,
  input  tie_pkg::in_word_t    word,
  output tie_pkg::scan_state_t st_nxt,
  output tie_pkg::out_word_t   res,
  output logic                 emit
);

  always_comb begin
    logic                is_digit;
    logic                is_dot;
    logic                ends_num;
    logic                has;
    logic                neg_e;
    logic                take_digit;
    logic [3:0]          dval;
    logic [31:0]         mag_base;
    logic [35:0]         sum;
    logic [35:0]         lim;
    logic                sat_now;
    logic [31:0]         mag_e;
    logic                sat_e;
    tie_pkg::sign_t      sign_b;

    is_digit   = (word.text_byte >= tie_pkg::CH_ZERO) && (word.text_byte <= tie_pkg::CH_NINE);
    is_dot     = (word.text_byte == tie_pkg::CH_DOT);
    dval       = 4'(word.text_byte - tie_pkg::CH_ZERO);
    ends_num   = st.inside_number && !is_digit && !is_dot;
    has        = st.inside_number || is_digit;
    neg_e      = st.inside_number ? st.is_negative : (st.pending_sign == tie_pkg::SIGN_MINUS);
    take_digit = is_digit && !(st.inside_number && st.after_dot);
    mag_base   = st.inside_number ? st.magnitude_acc : 32'd0;

    sum = {1'b0, mag_base, 3'b000} + {3'b000, mag_base, 1'b0} + {32'd0, dval};
    lim = neg_e ? tie_pkg::MAG_NEG_LIMIT : tie_pkg::MAG_POS_LIMIT;
    sat_now = (sum > lim);

    if (take_digit) begin
      mag_e = sat_now ? lim[31:0] : sum[31:0];
      sat_e = (st.inside_number && st.saturated_flag) || sat_now;
    end else begin
      mag_e = st.magnitude_acc;
      sat_e = st.saturated_flag;
    end

    if (word.text_byte == tie_pkg::CH_PLUS) begin
      sign_b = tie_pkg::SIGN_PLUS;
    end else if (word.text_byte == tie_pkg::CH_MINUS) begin
      sign_b = tie_pkg::SIGN_MINUS;
    end else begin
      sign_b = tie_pkg::SIGN_NONE;
    end

    emit = word.end_of_text || ends_num;

    res.has_number   = has;
    res.string_done  = word.end_of_text;
    res.overflowed   = has && sat_e;
    if (!has) begin
      res.number_value = 32'sd0;
    end else if (neg_e) begin
      res.number_value = $signed(32'd0 - mag_e);
    end else begin
      res.number_value = $signed(mag_e);
    end

    st_nxt = '0;
    if (word.end_of_text) begin
      st_nxt = '0;
    end else if (ends_num) begin
      st_nxt.pending_sign = sign_b;
    end else if (has) begin
      st_nxt.inside_number  = 1'b1;
      st_nxt.after_dot      = (st.inside_number && st.after_dot) || is_dot;
      st_nxt.is_negative    = neg_e;
      st_nxt.pending_sign   = tie_pkg::SIGN_NONE;
      st_nxt.magnitude_acc  = mag_e;
      st_nxt.saturated_flag = sat_e;
    end else begin
      st_nxt.pending_sign = sign_b;
    end
  end

endmodule

[rtl/core/text_integer_extractor.sv]
// Text integer extractor top level: input register, scan step, two-word result queue.
// Depends on tie_pkg, tie_scan_step and text_integer_extractor_macros.svh.
`timescale 1ns / 1ps

// Scans ASCII text one byte per word and returns each signed decimal integer it finds
// (digits, optionally led by a directly preceding '+' or '-', running on over digits and
// dots; value is the part before the first dot, saturated to 32-bit signed). A word gives
// a result only when it ends a number or carries end_of_text; the end_of_text word always
// gives exactly one result with string_done set. Throughput is one byte per clock while
// the result queue is not full: a byte is held in the input register, passes the scan
// step (one multiply-by-ten, add and limit compare) and lands in a two-word result
// queue; input keeps flowing while fewer than two results wait for out_ready.

module text_integer_extractor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tie_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tie_pkg::out_word_t out_data
);

`include "text_integer_extractor_macros.svh"

  logic                 in_valid_r;
  tie_pkg::in_word_t    in_word_r;
  tie_pkg::scan_state_t st_r;
  tie_pkg::scan_state_t st_nxt;
  tie_pkg::out_word_t   res;
  logic                 emit;
  logic                 adv;
  logic                 push;
  logic                 pop;
  tie_pkg::out_word_t   q_mem [2];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           cnt_r;
  logic [1:0]           cnt_nxt;

  tie_scan_step u_step (
    .st     (st_r),
    .word   (in_word_r),
    .st_nxt (st_nxt),
    .res    (res),
    .emit   (emit)
  );

  assign adv      = in_valid_r && (cnt_r != 2'd2);
  assign in_ready = !in_valid_r || adv;
  assign push     = adv && emit;
  assign pop      = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      st_r       <= '0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        st_r <= st_nxt;
      end
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_word_r <= in_data;
    end
    if (push) begin
      q_mem[wr_ptr_r] <= res;
    end
  end

  `TIE_ASSERT_NEXT(a_reset_after_end, adv && in_word_r.end_of_text, st_r == '0, "state not cleared after end of text")
  `TIE_ASSERT_NOW(a_empty_result_zero, push && !res.has_number, res.number_value == 32'sd0 && !res.overflowed, "result without number carries data")
  `TIE_ASSERT_NOW(a_sat_extreme, push && res.overflowed, res.number_value == 32'sh7FFFFFFF || res.number_value == 32'sh80000000, "saturated value not at a limit")
  `TIE_ASSERT_NOW(a_queue_bound, 1'b1, cnt_r != 2'd3, "result queue count out of range")

endmodule
